/* design/poid_pkg.sv */
package poid_pkg;

  localparam int PORT_W = 3;
  localparam int PIN_W  = 5;
  localparam int PRIO_W = 8;
  localparam int HID_W  = 8;
  localparam int FLAG_W = 32;

  // function codes of an input item
  localparam logic [1:0] FUNC_REG  = 2'd0;
  localparam logic [1:0] FUNC_REM  = 2'd1;
  localparam logic [1:0] FUNC_INTR = 2'd2;

  typedef struct packed {
    logic [PIN_W-1:0]  pin;
    logic [PRIO_W-1:0] prio;
  } ent_t;

  // command held steady for the whole walk along the row
  typedef struct packed {
    logic [1:0]        op;
    logic [PIN_W-1:0]  pin;
    logic [PRIO_W-1:0] prio;
    logic [FLAG_W-1:0] flags;
  } cmd_t;

  // token passed from cell to cell
  typedef struct packed {
    logic act;
    logic dropped;
    logic inserted;
    logic carry_vld;
    ent_t carry;
  } tok_t;

  typedef struct packed {
    logic             hit;
    logic [PIN_W-1:0] pin;
  } hit_t;

endpackage

/* design/poid_cell.sv */
module poid_cell #(
  parameter int NUM_PORTS = 5,
  parameter int HW        = 8,
  parameter int PW        = 3
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [PW-1:0]     cur_port,
  input  poid_pkg::cmd_t    cmd,
  input  logic [HW-1:0]     cmd_hid,
  input  poid_pkg::tok_t    tok_in,
  input  logic [HW-1:0]     tok_in_hid,
  output poid_pkg::tok_t    tok_out,
  output logic [HW-1:0]     tok_out_hid,
  output logic              own_vld,
  output poid_pkg::ent_t    own_ent,
  output logic [HW-1:0]     own_hid,
  input  logic              nb_vld,
  input  poid_pkg::ent_t    nb_ent,
  input  logic [HW-1:0]     nb_hid,
  output poid_pkg::hit_t    hit,
  output logic [HW-1:0]     hit_hid
);
  import poid_pkg::*;

  ent_t                 ent_mem [NUM_PORTS];
  logic [HW-1:0]        hid_mem [NUM_PORTS];
  logic [NUM_PORTS-1:0] vld;

  logic          is_upd;
  logic          drop_now;
  logic          use_nb;
  logic          c_vld;
  ent_t          c_ent;
  logic [HW-1:0] c_hid;
  logic          ins_here;
  logic          new_vld;
  ent_t          new_ent;
  logic [HW-1:0] new_hid;
  tok_t          tok_next;
  logic [HW-1:0] tok_hid_next;

  assign own_vld = vld[cur_port];
  assign own_ent = ent_mem[cur_port];
  assign own_hid = hid_mem[cur_port];

  assign is_upd = (cmd.op == FUNC_REG) || (cmd.op == FUNC_REM);

  always_comb begin
    // once the old entry of this pin has gone, everything slides left by one
    drop_now = !tok_in.dropped && own_vld && (own_ent.pin == cmd.pin);
    use_nb   = tok_in.dropped || drop_now;
    c_vld    = use_nb ? nb_vld : own_vld;
    c_ent    = use_nb ? nb_ent : own_ent;
    c_hid    = use_nb ? nb_hid : own_hid;
    ins_here = (cmd.op == FUNC_REG) && !tok_in.inserted &&
               (!c_vld || (c_ent.prio > cmd.prio));

    tok_next         = tok_in;
    tok_next.dropped = tok_in.dropped | drop_now;
    tok_hid_next     = tok_in_hid;
    new_vld          = c_vld;
    new_ent          = c_ent;
    new_hid          = c_hid;
    if (ins_here) begin
      new_vld            = 1'b1;
      new_ent.pin        = cmd.pin;
      new_ent.prio       = cmd.prio;
      new_hid            = cmd_hid;
      tok_next.inserted  = 1'b1;
      tok_next.carry_vld = c_vld;
      tok_next.carry     = c_ent;
      tok_hid_next       = c_hid;
    end else if (tok_in.inserted) begin
      // after the insertion point, everything slides right by one
      new_vld            = tok_in.carry_vld;
      new_ent            = tok_in.carry;
      new_hid            = tok_in_hid;
      tok_next.carry_vld = c_vld;
      tok_next.carry     = c_ent;
      tok_hid_next       = c_hid;
    end
  end

  always_comb begin
    hit.hit = tok_in.act && (cmd.op == FUNC_INTR) && own_vld && cmd.flags[own_ent.pin];
    hit.pin = hit.hit ? own_ent.pin : '0;
    hit_hid = hit.hit ? own_hid : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out <= '0;
      vld     <= '0;
    end else begin
      tok_out <= tok_next;
      if (tok_in.act && is_upd) begin
        vld[cur_port] <= new_vld;
      end
    end
  end

  always_ff @(posedge clk) begin
    tok_out_hid <= tok_hid_next;
    if (tok_in.act && is_upd) begin
      ent_mem[cur_port] <= new_ent;
      hid_mem[cur_port] <= new_hid;
    end
  end

endmodule

/* design/priority_ordered_pin_interrupt_dispatch_top.sv */
// Pin interrupt dispatcher. Each port keeps its handler list sorted by ascending
// priority (ties in registration order), one list position per cell of a row of
// PINS_PER_PORT cells. Every item, setup, remove or interrupt, walks the row once,
// one cell a clock, and busy stays high from the accepting edge until the walk
// ends, so a new item is taken only once the last one is through.
// Items with an unused function code, a port beyond NUM_PORTS or (for setup and
// remove) a pin beyond PINS_PER_PORT are taken and dropped at once. An interrupt
// item gives one strobe per flagged entry in list order, the last one marked by
// last; results cannot be held off, so the receiver must take each strobe as it
// comes. The final result appears on the cycle in which busy has already fallen.
module priority_ordered_pin_interrupt_dispatch_top #(
  parameter int NUM_PORTS     = 5,
  parameter int PINS_PER_PORT = 32,
  parameter int HANDLER_BITS  = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    func,
  input  logic [poid_pkg::PORT_W-1:0]   port,
  input  logic [poid_pkg::PIN_W-1:0]    pin,
  input  logic [poid_pkg::PRIO_W-1:0]   priority_req,
  input  logic [poid_pkg::HID_W-1:0]    handler_id,
  input  logic [poid_pkg::FLAG_W-1:0]   pending_flags,
  output logic                          strobe,
  output logic [poid_pkg::PORT_W-1:0]   out_port,
  output logic [poid_pkg::PIN_W-1:0]    out_pin,
  output logic [poid_pkg::HID_W-1:0]    out_handler,
  output logic                          last
);
  import poid_pkg::*;

  localparam int PW = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;
  localparam int HW = HANDLER_BITS;
  localparam int N  = PINS_PER_PORT;

  logic [PW-1:0] cur_port;
  cmd_t          cmd;
  logic [HW-1:0] cmd_hid;
  tok_t          launch;
  logic          pend_vld;
  logic [PIN_W-1:0] pend_pin;
  logic [HW-1:0] pend_hid;

  tok_t          tok     [N+1];
  logic [HW-1:0] tok_hid [N+1];
  logic          own_vld [N];
  ent_t          own_ent [N];
  logic [HW-1:0] own_hid [N];
  hit_t          hit_v   [N];
  logic [HW-1:0] hit_hid_v [N];

  logic             accept;
  logic             item_ok;
  logic             done;
  logic             hit_any;
  logic [PIN_W-1:0] hit_pin;
  logic [HW-1:0]    hit_hid;
  logic [N:0]       act_vec;

  assign accept = start && !busy;
  assign item_ok = ({1'b0, port} < (PORT_W + 1)'(NUM_PORTS)) &&
                   ((func == FUNC_INTR) ||
                    (((func == FUNC_REG) || (func == FUNC_REM)) &&
                     ({1'b0, pin} < (PIN_W + 1)'(PINS_PER_PORT))));
  assign done = tok[N].act;

  assign tok[0]     = launch;
  assign tok_hid[0] = '0;

  for (genvar k = 0; k < N; k++) begin : g_cell
    logic          nb_vld;
    ent_t          nb_ent;
    logic [HW-1:0] nb_hid;

    if (k < N - 1) begin : g_nb
      assign nb_vld = own_vld[k+1];
      assign nb_ent = own_ent[k+1];
      assign nb_hid = own_hid[k+1];
    end else begin : g_end
      assign nb_vld = 1'b0;
      assign nb_ent = '0;
      assign nb_hid = '0;
    end

    poid_cell #(
      .NUM_PORTS (NUM_PORTS),
      .HW        (HW),
      .PW        (PW)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .cur_port    (cur_port),
      .cmd         (cmd),
      .cmd_hid     (cmd_hid),
      .tok_in      (tok[k]),
      .tok_in_hid  (tok_hid[k]),
      .tok_out     (tok[k+1]),
      .tok_out_hid (tok_hid[k+1]),
      .own_vld     (own_vld[k]),
      .own_ent     (own_ent[k]),
      .own_hid     (own_hid[k]),
      .nb_vld      (nb_vld),
      .nb_ent      (nb_ent),
      .nb_hid      (nb_hid),
      .hit         (hit_v[k]),
      .hit_hid     (hit_hid_v[k])
    );
  end

  // only the cell holding the token can report a hit, so the bus is a plain OR
  always_comb begin
    hit_any = 1'b0;
    hit_pin = '0;
    hit_hid = '0;
    for (int k = 0; k < N; k++) begin
      hit_any = hit_any | hit_v[k].hit;
      hit_pin = hit_pin | hit_v[k].pin;
      hit_hid = hit_hid | hit_hid_v[k];
    end
  end

  always_comb begin
    for (int k = 0; k <= N; k++) begin
      act_vec[k] = tok[k].act;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      launch   <= '0;
      pend_vld <= 1'b0;
      strobe   <= 1'b0;
    end else begin
      launch.act <= accept && item_ok;
      // hold one hit back so the final one can be marked
      strobe     <= (hit_any || done) && pend_vld;
      if (accept && item_ok) begin
        busy            <= 1'b1;
        launch.dropped  <= 1'b0;
        launch.inserted <= 1'b0;
      end
      if (hit_any) begin
        pend_vld <= 1'b1;
      end
      if (done) begin
        busy     <= 1'b0;
        pend_vld <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && item_ok) begin
      cur_port  <= port[PW-1:0];
      cmd.op    <= func;
      cmd.pin   <= pin;
      cmd.prio  <= priority_req;
      cmd.flags <= pending_flags;
      cmd_hid   <= HW'(handler_id);
    end
    if (hit_any) begin
      pend_pin <= hit_pin;
      pend_hid <= hit_hid;
    end
    if (hit_any || done) begin
      out_port    <= PORT_W'(cur_port);
      out_pin     <= pend_pin;
      out_handler <= HID_W'(pend_hid);
      last        <= done;
    end
  end

`ifndef NO_ASSERTIONS
  a_one_token: assert property (@(posedge clk) disable iff (rst)
    $onehot0(act_vec))
    else $error("more than one token in the cell row");

  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (strobe && last) |-> !busy)
    else $error("final result shown while still busy");

  a_mid_busy: assert property (@(posedge clk) disable iff (rst)
    (strobe && !last) |-> busy)
    else $error("non-final result outside an item");

  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> (busy && !launch.act))
    else $error("walk ended with no item in progress");
`endif

endmodule

/* tb/tb_priority_ordered_pin_interrupt_dispatch_top.sv */
module tb_priority_ordered_pin_interrupt_dispatch_top;
  import poid_pkg::*;

  localparam int N_PORTS = 5;
  localparam int N_PINS = 32;
  localparam int WATCHDOG_CYCLES = 2000;
  localparam int RANDOM_ITEMS = 165;
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]        func;
    logic [PORT_W-1:0] port;
    logic [PIN_W-1:0]  pin;
    logic [PRIO_W-1:0] prio;
    logic [HID_W-1:0]  hid;
    logic [FLAG_W-1:0] flags;
  } irq_item_t;

  typedef struct packed {
    logic [PIN_W-1:0]  pin;
    logic [PRIO_W-1:0] prio;
    logic [HID_W-1:0]  hid;
  } hdl_ent_t;

  typedef struct packed {
    logic [PORT_W-1:0] port;
    logic [PIN_W-1:0]  pin;
    logic [HID_W-1:0]  hid;
    logic              last;
  } dispatch_t;

  // typed rows carry at most one dispatch, written in by hand
  typedef struct packed {
    irq_item_t        it;
    logic             typed;
    logic             k_one;
    logic [PIN_W-1:0] k_pin;
    logic [HID_W-1:0] k_hid;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst;
  logic start;
  logic busy;
  logic [1:0] func;
  logic [PORT_W-1:0] port;
  logic [PIN_W-1:0] pin;
  logic [PRIO_W-1:0] priority_req;
  logic [HID_W-1:0] handler_id;
  logic [FLAG_W-1:0] pending_flags;
  logic strobe;
  logic [PORT_W-1:0] out_port;
  logic [PIN_W-1:0] out_pin;
  logic [HID_W-1:0] out_handler;
  logic last;

  hdl_ent_t hlist [N_PORTS][N_PINS];
  int unsigned hlen [N_PORTS];
  dispatch_t dispatch_q [$];
  dir_row_t dir_rows [$];
  int mismatch_cnt = 0;
  int idle_cycles = 0;
  bit calm = 1'b0;

  priority_ordered_pin_interrupt_dispatch_top dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .func(func),
    .port(port),
    .pin(pin),
    .priority_req(priority_req),
    .handler_id(handler_id),
    .pending_flags(pending_flags),
    .strobe(strobe),
    .out_port(out_port),
    .out_pin(out_pin),
    .out_handler(out_handler),
    .last(last)
  );

  always #5 clk = ~clk;

  task automatic flag_mismatch(input string what);
    mismatch_cnt++;
    if (mismatch_cnt <= 50) $display("[%0t] dispatch mismatch: %s", $time, what);
  endtask

  // applies one item to the per-port handler lists, queues the dispatches it causes
  function automatic void apply_to_lists(input irq_item_t it);
    int p;
    int w;
    int pos;
    int k;
    int nhit;
    int seen;
    dispatch_t d;
    p = int'(it.port);
    if (p >= N_PORTS) return;
    if (it.func == FUNC_REG || it.func == FUNC_REM) begin
      w = 0;
      for (k = 0; k < hlen[p]; k++) begin
        if (hlist[p][k].pin != it.pin) begin
          hlist[p][w] = hlist[p][k];
          w++;
        end
      end
      hlen[p] = w;
      if (it.func == FUNC_REG && w < N_PINS) begin
        pos = 0;
        while (pos < w && hlist[p][pos].prio <= it.prio) pos++;
        for (k = w; k > pos; k--) hlist[p][k] = hlist[p][k-1];
        hlist[p][pos].pin = it.pin;
        hlist[p][pos].prio = it.prio;
        hlist[p][pos].hid = it.hid;
        hlen[p] = w + 1;
      end
    end else if (it.func == FUNC_INTR) begin
      nhit = 0;
      for (k = 0; k < hlen[p]; k++)
        if (it.flags[hlist[p][k].pin]) nhit++;
      seen = 0;
      for (k = 0; k < hlen[p]; k++) begin
        if (it.flags[hlist[p][k].pin]) begin
          seen++;
          d.port = it.port;
          d.pin = hlist[p][k].pin;
          d.hid = hlist[p][k].hid;
          d.last = (seen == nhit);
          dispatch_q.push_back(d);
        end
      end
    end
  endfunction

  task automatic add_row(input logic [1:0] f, input logic [PORT_W-1:0] pt,
                         input logic [PIN_W-1:0] pn, input logic [PRIO_W-1:0] pr,
                         input logic [HID_W-1:0] h, input logic [FLAG_W-1:0] fl,
                         input logic typed, input logic k_one,
                         input logic [PIN_W-1:0] k_pin, input logic [HID_W-1:0] k_hid);
    dir_row_t r;
    r.it.func = f;
    r.it.port = pt;
    r.it.pin = pn;
    r.it.prio = pr;
    r.it.hid = h;
    r.it.flags = fl;
    r.typed = typed;
    r.k_one = k_one;
    r.k_pin = k_pin;
    r.k_hid = k_hid;
    dir_rows.push_back(r);
  endtask

  // called at a rising edge; returns at the edge that takes the item
  task automatic send_item(input dir_row_t r);
    dispatch_t d;
    if (!calm && $urandom_range(99, 0) < 15) begin
      start <= 1'b0;
      repeat ($urandom_range(40, 1)) @(posedge clk);
    end
    start <= 1'b1;
    func <= r.it.func;
    port <= r.it.port;
    pin <= r.it.pin;
    priority_req <= r.it.prio;
    handler_id <= r.it.hid;
    pending_flags <= r.it.flags;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (r.typed) begin
      if (r.k_one) begin
        d.port = r.it.port;
        d.pin = r.k_pin;
        d.hid = r.k_hid;
        d.last = 1'b1;
        dispatch_q.push_back(d);
      end
    end else begin
      apply_to_lists(r.it);
    end
  endtask

  // sender holds off until every queued dispatch is out, then lets the walk finish
  task automatic drain();
    start <= 1'b0;
    while (dispatch_q.size() != 0) @(posedge clk);
    repeat (N_PINS + 4) @(posedge clk);
  endtask

  always @(posedge clk) begin : dispatch_check
    dispatch_t want;
    if (!rst && strobe) begin
      if (dispatch_q.size() == 0) begin
        flag_mismatch($sformatf("unexpected dispatch port %0d pin %0d handler %0h last %0b",
                                out_port, out_pin, out_handler, last));
      end else begin
        want = dispatch_q.pop_front();
        if (out_port !== want.port || out_pin !== want.pin ||
            out_handler !== want.hid || last !== want.last)
          flag_mismatch($sformatf("got port %0d pin %0d hid %0h last %0b, want %0d %0d %0h %0b",
                                  out_port, out_pin, out_handler, last,
                                  want.port, want.pin, want.hid, want.last));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || strobe) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_CYCLES) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    int i;
    int j;
    int k;
    int t;
    int sel;
    int fill_port;
    int order [N_PINS];
    dir_row_t r;

    rst <= 1'b1;
    start <= 1'b0;
    func <= '0;
    port <= '0;
    pin <= '0;
    priority_req <= '0;
    handler_id <= '0;
    pending_flags <= '0;
    for (k = 0; k < N_PORTS; k++) hlen[k] = 0;

    // interrupt on an empty list, priority extremes, equal priorities keep order,
    // re-registration moves the pin, removal of absent pin, ignored codes and ports
    add_row(FUNC_INTR, 3'd0, 5'd0, 8'h00, 8'h00, 32'hFFFF_FFFF, 1'b1, 1'b0, 5'd0, 8'h00);
    add_row(FUNC_REG, 3'd0, 5'd0, 8'h00, 8'h00, 32'h0, 1'b0, 1'b0, 5'd0, 8'h00);
    add_row(FUNC_REG, 3'd0, 5'd31, 8'hFF, 8'hFF, 32'h0, 1'b0, 1'b0, 5'd0, 8'h00);
    add_row(FUNC_INTR, 3'd0, 5'd0, 8'h00, 8'h00, 32'h8000_0000, 1'b1, 1'b1, 5'd31, 8'hFF);
    add_row(FUNC_INTR, 3'd0, 5'd0, 8'h00, 8'h00, 32'hFFFF_FFFF, 1'b0, 1'b0, 5'd0, 8'h00);
    add_row(FUNC_REG, 3'd0, 5'd5, 8'hFF, 8'hAA, 32'h0, 1'b0, 1'b0, 5'd0, 8'h00);
    add_row(FUNC_REG, 3'd0, 5'd7, 8'h80, 8'h55, 32'h0, 1'b0, 1'b0, 5'd0, 8'h00);
    add_row(FUNC_REG, 3'd0, 5'd0, 8'hC8, 8'h12, 32'h0, 1'b0, 1'b0, 5'd0, 8'h00);
    add_row(FUNC_INTR, 3'd0, 5'd0, 8'h00, 8'h00, 32'hFFFF_FFFF, 1'b0, 1'b0, 5'd0, 8'h00);
    add_row(FUNC_REG, 3'd0, 5'd7, 8'h80, 8'h66, 32'h0, 1'b0, 1'b0, 5'd0, 8'h00);
    add_row(FUNC_REM, 3'd0, 5'd31, 8'h00, 8'h00, 32'h0, 1'b0, 1'b0, 5'd0, 8'h00);
    add_row(FUNC_REM, 3'd0, 5'd9, 8'h00, 8'h00, 32'h0, 1'b0, 1'b0, 5'd0, 8'h00);
    add_row(FUNC_INTR, 3'd0, 5'd0, 8'h00, 8'h00, 32'h0, 1'b1, 1'b0, 5'd0, 8'h00);
    add_row(FUNC_INTR, 3'd0, 5'd0, 8'h00, 8'h00, 32'hFFFF_FFFF, 1'b0, 1'b0, 5'd0, 8'h00);
    add_row(FUNC_UNUSED, 3'd0, 5'd5, 8'h00, 8'h00, 32'hFFFF_FFFF, 1'b1, 1'b0, 5'd0, 8'h00);
    add_row(FUNC_REG, 3'd5, 5'd1, 8'h03, 8'h77, 32'h0, 1'b1, 1'b0, 5'd0, 8'h00);
    add_row(FUNC_INTR, 3'd7, 5'd0, 8'h00, 8'h00, 32'hFFFF_FFFF, 1'b1, 1'b0, 5'd0, 8'h00);
    add_row(FUNC_REG, 3'd4, 5'd1, 8'h0A, 8'h01, 32'h0, 1'b0, 1'b0, 5'd0, 8'h00);
    add_row(FUNC_INTR, 3'd4, 5'd0, 8'h00, 8'h00, 32'h0000_0002, 1'b1, 1'b1, 5'd1, 8'h01);
    add_row(FUNC_INTR, 3'd4, 5'd0, 8'h00, 8'h00, 32'hFFFF_FFFD, 1'b1, 1'b0, 5'd0, 8'h00);
    add_row(FUNC_INTR, 3'd3, 5'd0, 8'h00, 8'h00, 32'hFFFF_FFFF, 1'b1, 1'b0, 5'd0, 8'h00);
    add_row(FUNC_REM, 3'd5, 5'd5, 8'h00, 8'h00, 32'h0, 1'b1, 1'b0, 5'd0, 8'h00);
    add_row(FUNC_INTR, 3'd0, 5'd0, 8'h00, 8'h00, 32'hFFFF_FFFF, 1'b0, 1'b0, 5'd0, 8'h00);

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) send_item(dir_rows[i]);
    drain();

    // fill one port completely in shuffled pin order with clustered priorities,
    // then raise every flag so the whole list is dispatched
    r = '0;
    fill_port = $urandom_range(N_PORTS - 1, 0);
    for (k = 0; k < N_PINS; k++) order[k] = k;
    for (k = N_PINS - 1; k > 0; k--) begin
      j = $urandom_range(k, 0);
      t = order[k];
      order[k] = order[j];
      order[j] = t;
    end
    for (k = 0; k < N_PINS; k++) begin
      r.it.func = FUNC_REG;
      r.it.port = PORT_W'(fill_port);
      r.it.pin = PIN_W'(order[k]);
      r.it.prio = PRIO_W'($urandom_range(15, 0));
      r.it.hid = HID_W'($urandom);
      r.it.flags = $urandom;
      send_item(r);
    end
    r.it.func = FUNC_INTR;
    r.it.flags = '1;
    send_item(r);

    for (i = 0; i < RANDOM_ITEMS; i++) begin
      calm = (i >= 40 && i < 100);
      if (i == 120) drain();
      sel = $urandom_range(99, 0);
      r.it.func = (sel < 50) ? FUNC_REG : (sel < 65) ? FUNC_REM :
                  (sel < 95) ? FUNC_INTR : FUNC_UNUSED;
      r.it.port = PORT_W'(($urandom_range(9, 0) == 0) ? $urandom_range(7, 5) :
                                                         $urandom_range(4, 0));
      r.it.pin = PIN_W'($urandom_range(31, 0));
      r.it.prio = PRIO_W'($urandom_range(1, 0) ? $urandom_range(7, 0) :
                                                 $urandom_range(255, 0));
      r.it.hid = HID_W'($urandom);
      sel = $urandom_range(9, 0);
      r.it.flags = (sel < 2) ? '1 : (sel < 4) ? ($urandom & $urandom & $urandom) : $urandom;
      send_item(r);
    end
    calm = 1'b0;
    drain();

    if (mismatch_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

/* priority_ordered_pin_interrupt_dispatch_top.f */
design/poid_pkg.sv
design/poid_cell.sv
design/priority_ordered_pin_interrupt_dispatch_top.sv
tb/tb_priority_ordered_pin_interrupt_dispatch_top.sv
